@@ rtl/espf_pkg.sv @@
`timescale 1ns / 1ps

package espf_pkg;

    localparam int BLOCK_BYTES_DEF = 8;
    localparam int NUM_SA_DEF      = 16;

    localparam int BYTE_W    = 8;
    localparam int SPI_W     = 32;
    localparam int CTR_W     = 32;
    localparam int IV_W      = 64;
    localparam int SA_IDX_W  = 4;
    localparam int HDR_BYTES = 16;
    localparam int HDR_IDX_W = 4;
    localparam int HDR_W     = SPI_W + CTR_W + IV_W;
    // Wide enough for a header byte index and for a pad count below 32.
    localparam int CNT_W     = 5;

    typedef enum logic {
        OP_DATA = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_HDR  = 6'b000010,
        S_DATA = 6'b000100,
        S_PAD  = 6'b001000,
        S_PLEN = 6'b010000,
        S_NXT  = 6'b100000
    } t_state;

    typedef struct packed {
        logic              first;
        logic              last;
        logic [BYTE_W-1:0] data;
        logic [SPI_W-1:0]  spi;
        logic [IV_W-1:0]   iv;
        logic [BYTE_W-1:0] pad;
        logic [BYTE_W-1:0] nproto;
    } t_item;

    typedef struct packed {
        logic idle;
        logic done;
    } t_emit_stat;

endpackage

@@ rtl/espf_in_if.sv @@
`timescale 1ns / 1ps

interface espf_in_if;
    import espf_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [BYTE_W-1:0]   data_byte;
    logic                first;
    logic                last;
    logic [SPI_W-1:0]    spi;
    logic [IV_W-1:0]     init_vector;
    logic [BYTE_W-1:0]   next_proto;
    logic [SA_IDX_W-1:0] sa_index;
    logic [CTR_W-1:0]    counter_value;

    modport source (
        output valid, op, data_byte, first, last, spi, init_vector, next_proto,
               sa_index, counter_value,
        input  ready
    );

    modport sink (
        input  valid, op, data_byte, first, last, spi, init_vector, next_proto,
               sa_index, counter_value,
        output ready
    );
endinterface

@@ rtl/espf_out_if.sv @@
`timescale 1ns / 1ps

interface espf_out_if;
    import espf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_first;
    logic              out_last;

    modport source (
        output valid, out_byte, out_first, out_last,
        input  ready
    );

    modport sink (
        input  valid, out_byte, out_first, out_last,
        output ready
    );
endinterface

@@ rtl/espf_ram.sv @@
`timescale 1ns / 1ps

module espf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/espf_emit.sv @@
`timescale 1ns / 1ps

module espf_emit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  espf_pkg::t_item           i_item,
    input  logic                      i_ctr_vld,
    input  logic [espf_pkg::CTR_W-1:0] i_ctr,
    output espf_pkg::t_emit_stat      o_stat,
    espf_out_if.source                o_out
);
    import espf_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_item              r_item;
    logic [CTR_W-1:0]   r_ctr;
    logic               r_ov;
    logic [BYTE_W-1:0]  r_obyte;
    logic               r_ofirst;
    logic               r_olast;

    logic [HDR_W-1:0]     hdr_vec;
    logic [HDR_IDX_W-1:0] hdr_sel;
    logic [BYTE_W-1:0]    byte_val;
    logic                 first_flag;
    logic                 last_flag;
    logic                 active;
    logic                 final_byte;
    logic                 emit;

    assign hdr_vec = {r_item.spi, r_ctr, r_item.iv};
    assign hdr_sel = HDR_IDX_W'(HDR_BYTES - 1) - r_cnt[HDR_IDX_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        byte_val   = '0;
        first_flag = 1'b0;
        last_flag  = 1'b0;
        active     = 1'b1;
        final_byte = 1'b0;
        case (r_state)
            S_IDLE: begin
                active = 1'b0;
            end
            S_HDR: begin
                byte_val   = hdr_vec[{hdr_sel, 3'b000} +: BYTE_W];
                first_flag = (r_cnt == '0);
                if (r_cnt == CNT_W'(HDR_BYTES - 1)) begin
                    n_state = S_DATA;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DATA: begin
                byte_val = r_item.data;
                n_cnt    = '0;
                if (r_item.last) begin
                    n_state = (r_item.pad != '0) ? S_PAD : S_PLEN;
                end else begin
                    final_byte = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_PAD: begin
                // Pad bytes count up from one.
                byte_val = BYTE_W'(r_cnt) + 1'b1;
                if (byte_val == r_item.pad) begin
                    n_state = S_PLEN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_PLEN: begin
                byte_val = r_item.pad;
                n_state  = S_NXT;
            end
            S_NXT: begin
                byte_val   = r_item.nproto;
                last_flag  = 1'b1;
                final_byte = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                active  = 1'b0;
                n_state = S_IDLE;
            end
        endcase
    end

    assign emit        = active && (!r_ov || o_out.ready);
    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = emit && final_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_load) begin
                r_state <= i_item.first ? S_HDR : S_DATA;
                r_cnt   <= '0;
            end else if (emit) begin
                r_state <= n_state;
                r_cnt   <= n_cnt;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
        if (i_ctr_vld) begin
            r_ctr <= i_ctr;
        end
        if (emit) begin
            r_obyte  <= byte_val;
            r_ofirst <= first_flag;
            r_olast  <= last_flag;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_byte  = r_obyte;
    assign o_out.out_first = r_ofirst;
    assign o_out.out_last  = r_olast;
endmodule

@@ rtl/esp_encapsulation_framer.sv @@
`timescale 1ns / 1ps

// ESP encapsulation framer. Each request on i_in carries one packet byte (op data) or a
// replay counter load for one security association (op load). A byte marked first is
// preceded on o_out by a 16-byte ESP header: the SPI and the SA's replay counter, both
// big-endian, then the eight IV bytes, most significant first. A byte marked last is
// followed by the trailer: pad bytes 1, 2, 3 and so on up to the pad count, then the pad
// length, then the next-header byte (flagged by out_last); the pad brings payload and
// trailer to a multiple of the cipher block size BLOCK_BYTES. Plain payload bytes pass
// through at one per cycle while o_out is not stalled; a request produces 1 to 16 + 1 +
// BLOCK_BYTES + 1 bytes through the single byte-wide output register. A load produces
// nothing. The replay counters live in a one-port-write RAM with registered read; after
// reset the block clears that RAM to zero and accepts no request until the pass is over
// (replay_start writes are taken). The SA index wraps modulo NUM_SA. Write replay_start
// only while the block is idle.
module esp_encapsulation_framer #(
    parameter int BLOCK_BYTES = espf_pkg::BLOCK_BYTES_DEF,
    parameter int NUM_SA      = espf_pkg::NUM_SA_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [espf_pkg::CTR_W-1:0] i_cfg_wdata,
    espf_in_if.sink                    i_in,
    espf_out_if.source                 o_out
);
    import espf_pkg::*;

    localparam int SA_AW = (NUM_SA > 1) ? $clog2(NUM_SA) : 1;
    localparam int LEN_W = $clog2(BLOCK_BYTES);
    // Holds a length plus two, which can reach BLOCK_BYTES + 1.
    localparam int SUM_W = LEN_W + 2;

    // Configuration and framing state.
    logic [CTR_W-1:0]  r_start;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_held;

    // Clearing pass over the counter RAM after reset.
    logic              r_clr;
    logic [SA_AW-1:0]  r_clr_addr;

    // A header request has read its counter; the next cycle writes it back.
    logic              r_rd_pend;
    logic [SA_AW-1:0]  r_sa;

    logic              acc;
    logic              acc_pkt;
    logic [SA_AW-1:0]  sa_idx;
    logic [LEN_W-1:0]  len_base;
    logic [LEN_W-1:0]  len_next;
    logic [SUM_W-1:0]  len_sum;
    logic [SUM_W-1:0]  len_mod;
    logic [SUM_W-1:0]  pad_val;

    logic              ram_we;
    logic [SA_AW-1:0]  ram_waddr;
    logic [CTR_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [CTR_W-1:0]  ram_rdata;
    logic [CTR_W-1:0]  ctr_next;

    t_item             item;
    t_emit_stat        emit_stat;

    // The request is taken, once the clearing pass is over, when the emitter is free or hands off its final byte.
    assign i_in.ready = !r_clr && (emit_stat.idle || emit_stat.done);
    assign acc        = i_in.valid && i_in.ready;
    assign acc_pkt    = acc && (i_in.op == OP_DATA);

    // SA index modulo NUM_SA, as a small constant table over the 4-bit field.
    always_comb begin
        sa_idx = '0;
        for (int k = 0; k < (1 << SA_IDX_W); k++) begin
            if (i_in.sa_index == SA_IDX_W'(k)) begin
                sa_idx = SA_AW'(k % NUM_SA);
            end
        end
    end

    // Payload length modulo the block size and the pad that, with the two trailer bytes, completes the block.
    always_comb begin
        len_base = i_in.first ? '0 : r_len;
        len_next = (len_base == LEN_W'(BLOCK_BYTES - 1)) ? '0 : len_base + 1'b1;
        len_sum  = SUM_W'(len_next) + SUM_W'(2);
        len_mod  = (len_sum >= SUM_W'(BLOCK_BYTES)) ? len_sum - SUM_W'(BLOCK_BYTES) : len_sum;
        pad_val  = (len_mod == '0) ? '0 : SUM_W'(BLOCK_BYTES) - len_mod;
    end

    always_comb begin
        item.first  = i_in.first;
        item.last   = i_in.last;
        item.data   = i_in.data_byte;
        item.spi    = i_in.spi;
        item.iv     = i_in.init_vector;
        item.pad    = BYTE_W'(pad_val);
        item.nproto = i_in.first ? i_in.next_proto : r_held;
    end

    // A counter of zero moves to replay_start; any other value counts up and wraps.
    assign ctr_next = (ram_rdata == '0) ? r_start : ram_rdata + 1'b1;

    // One write port: the clearing pass, a load request, or the header write-back. A
    // load can never meet a write-back, since the emitter is still busy with the header
    // when the write-back comes.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = sa_idx;
        ram_wdata = i_in.counter_value;
        if (r_clr) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (acc && (i_in.op == OP_LOAD)) begin
            ram_we = 1'b1;
        end else if (r_rd_pend) begin
            ram_we    = 1'b1;
            ram_waddr = r_sa;
            ram_wdata = ctr_next;
        end
    end

    assign ram_re = acc_pkt && i_in.first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= CTR_W'(1);
            r_len      <= '0;
            r_held     <= '0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_rd_pend  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == SA_AW'(NUM_SA - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (acc_pkt) begin
                r_len <= i_in.last ? '0 : len_next;
                if (i_in.first) begin
                    r_held <= i_in.next_proto;
                end
            end
            r_rd_pend <= ram_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_sa <= sa_idx;
        end
    end

    espf_ram #(
        .WIDTH (CTR_W),
        .DEPTH (NUM_SA),
        .AW    (SA_AW)
    ) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (sa_idx),
        .o_rdata (ram_rdata)
    );

    espf_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (acc_pkt),
        .i_item    (item),
        .i_ctr_vld (r_rd_pend),
        .i_ctr     (ram_rdata),
        .o_stat    (emit_stat),
        .o_out     (o_out)
    );
endmodule
